// File: hdl/sght_pkg.sv
`default_nettype none

package sght_pkg;

  localparam int TEMP_W  = 12;
  localparam int MV_W    = 16;
  localparam int MA_W    = 19;
  localparam int WATT_W  = 12;
  localparam int TIME_W  = 32;
  localparam int TOUT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 19;

  // Heater current in mA is power in mW times this over the battery voltage in mV.
  localparam int MA_PER_MW_MV = 1000;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_ON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_MV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_ON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_KEEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd7;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_ON_TEMP  = 3'd1,
    ACT_OFF_TEMP = 3'd2,
    ACT_OFF_PWR  = 3'd3,
    ACT_OFF_FAIL = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/sght_div.sv
`default_nettype none

module sght_div #(
  parameter int DIV_W = 25,
  parameter logic [DIV_W-1:0] DIVIDEND = '0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      step,
  input  wire logic [sght_pkg::MV_W-1:0] divisor,
  output logic                           last,
  output logic [DIV_W-1:0]               quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [sght_pkg::MV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]          dq_r, dq_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [sght_pkg::MV_W:0]   rem_sh;
  logic [sght_pkg::MV_W:0]   rem_sub;
  logic                      ge;

  // Restoring division, one quotient bit per step, dividend shifted out MSB first.
  always_comb begin
    rem_sh  = {rem_r, dq_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      dq_nxt  = DIVIDEND;
      cnt_nxt = CNT_W'(DIV_W - 1);
    end else if (step) begin
      rem_nxt = ge ? rem_sub[sght_pkg::MV_W-1:0] : rem_sh[sght_pkg::MV_W-1:0];
      dq_nxt  = {dq_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign last     = cnt_r == '0;
  assign quotient = dq_r;

endmodule

`default_nettype wire

// File: hdl/sght_dp.sv
`default_nettype none

module sght_dp #(
  parameter int HEATER_POWER_MW      = 16800,
  parameter int MIN_VALID_BATTERY_MV = 1000
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sght_pkg::cmd_t                      cmd,
  output sght_pkg::status_t                        status,
  input  wire logic                                cfg_we,
  input  wire logic [sght_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sght_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic [sght_pkg::TIME_W-1:0]         now_ms,
  input  wire logic                                sensor_present,
  input  wire logic signed [sght_pkg::TEMP_W-1:0]  water_temp,
  input  wire logic [sght_pkg::MV_W-1:0]           battery_mv,
  input  wire logic [sght_pkg::MV_W-1:0]           panel_mv,
  input  wire logic signed [sght_pkg::MA_W-1:0]    battery_ma,
  input  wire logic [sght_pkg::WATT_W-1:0]         panel_watts,
  output logic                                     relay_on,
  output logic                                     power_ok,
  output sght_pkg::action_t                        action
);

  localparam int DIVIDEND_I = HEATER_POWER_MW * sght_pkg::MA_PER_MW_MV;
  localparam int DIV_W      = $clog2(DIVIDEND_I + 1);
  localparam int SUM_W      = (DIV_W > sght_pkg::MA_W ? DIV_W : sght_pkg::MA_W) + 2;
  localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(DIVIDEND_I);
  localparam logic [sght_pkg::MV_W-1:0] MIN_MV = sght_pkg::MV_W'(MIN_VALID_BATTERY_MV);

  logic signed [sght_pkg::TEMP_W-1:0] temp_on_r, temp_off_r;
  logic [sght_pkg::MV_W-1:0]          cutoff_r;
  logic signed [sght_pkg::MA_W-1:0]   margin_on_r, margin_off_r;
  logic [sght_pkg::WATT_W-1:0]        panel_on_r, panel_keep_r;
  logic [sght_pkg::TOUT_W-1:0]        timeout_r;

  logic [sght_pkg::TIME_W-1:0]        now_r;
  logic                               present_r;
  logic signed [sght_pkg::TEMP_W-1:0] temp_r;
  logic [sght_pkg::MV_W-1:0]          bmv_r, pmv_r;
  logic signed [sght_pkg::MA_W-1:0]   bma_r;
  logic [sght_pkg::WATT_W-1:0]        pw_r;

  logic                        relay_r, relay_nxt;
  logic                        lost_r, lost_nxt;
  logic [sght_pkg::TIME_W-1:0] since_r, since_nxt;
  logic                        out_power_r;
  sght_pkg::action_t           out_action_r, action_nxt;

  logic [DIV_W-1:0]            quotient;
  logic                        by_cutoff, panel_ok, trend_ok, pwr_ok;
  logic signed [SUM_W-1:0]     est, surplus;
  logic [sght_pkg::TIME_W-1:0] elapsed;
  logic                        expired;

  sght_div #(
    .DIV_W    (DIV_W),
    .DIVIDEND (DIVIDEND)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .step     (cmd.step),
    .divisor  (bmv_r),
    .last     (status.div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_on_r    <= 12'sd320;
      temp_off_r   <= 12'sd384;
      cutoff_r     <= 16'd11800;
      margin_on_r  <= 19'sd200;
      margin_off_r <= 19'sd50;
      panel_on_r   <= 12'd23;
      panel_keep_r <= 12'd20;
      timeout_r    <= 16'd30000;
    end else if (cfg_we) begin
      case (cfg_index)
        sght_pkg::CFG_TEMP_ON:    temp_on_r    <= cfg_wdata[sght_pkg::TEMP_W-1:0];
        sght_pkg::CFG_TEMP_OFF:   temp_off_r   <= cfg_wdata[sght_pkg::TEMP_W-1:0];
        sght_pkg::CFG_CUTOFF_MV:  cutoff_r     <= cfg_wdata[sght_pkg::MV_W-1:0];
        sght_pkg::CFG_MARGIN_ON:  margin_on_r  <= cfg_wdata[sght_pkg::MA_W-1:0];
        sght_pkg::CFG_MARGIN_OFF: margin_off_r <= cfg_wdata[sght_pkg::MA_W-1:0];
        sght_pkg::CFG_PANEL_ON:   panel_on_r   <= cfg_wdata[sght_pkg::WATT_W-1:0];
        sght_pkg::CFG_PANEL_KEEP: panel_keep_r <= cfg_wdata[sght_pkg::WATT_W-1:0];
        sght_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_wdata[sght_pkg::TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= now_ms;
      present_r <= sensor_present;
      temp_r    <= water_temp;
      bmv_r     <= battery_mv;
      pmv_r     <= panel_mv;
      bma_r     <= battery_ma;
      pw_r      <= panel_watts;
    end
  end

  always_comb begin
    by_cutoff = (bmv_r > cutoff_r) || (pmv_r > cutoff_r);
    panel_ok  = relay_r ? (pw_r >= panel_keep_r) : (pw_r >= panel_on_r);
    est       = (bmv_r >= MIN_MV) ? $signed({{(SUM_W-DIV_W){1'b0}}, quotient}) : '0;
    surplus   = SUM_W'(bma_r) - est;
    trend_ok  = relay_r ? (bma_r >= margin_off_r) : (surplus >= SUM_W'(margin_on_r));
    pwr_ok    = by_cutoff || (panel_ok && trend_ok);
    elapsed   = lost_r ? (now_r - since_r) : '0;
    expired   = elapsed >= {{(sght_pkg::TIME_W-sght_pkg::TOUT_W){1'b0}}, timeout_r};

    relay_nxt  = relay_r;
    lost_nxt   = lost_r;
    since_nxt  = since_r;
    action_nxt = sght_pkg::ACT_NONE;
    if (!present_r) begin
      lost_nxt = 1'b1;
      if (!lost_r) begin
        since_nxt = now_r;
      end
      if (expired) begin
        relay_nxt = 1'b0;
        if (relay_r) begin
          action_nxt = sght_pkg::ACT_OFF_FAIL;
        end
      end
    end else begin
      lost_nxt = 1'b0;
      if (!pwr_ok) begin
        relay_nxt = 1'b0;
        if (relay_r) begin
          action_nxt = sght_pkg::ACT_OFF_PWR;
        end
      end else if (!relay_r && (temp_r <= temp_on_r)) begin
        relay_nxt  = 1'b1;
        action_nxt = sght_pkg::ACT_ON_TEMP;
      end else if (relay_r && (temp_r >= temp_off_r)) begin
        relay_nxt  = 1'b0;
        action_nxt = sght_pkg::ACT_OFF_TEMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r <= 1'b0;
      lost_r  <= 1'b0;
      since_r <= '0;
    end else if (cmd.commit) begin
      relay_r <= relay_nxt;
      lost_r  <= lost_nxt;
      since_r <= since_nxt;
    end
    if (cmd.commit) begin
      out_power_r  <= pwr_ok;
      out_action_r <= action_nxt;
    end
  end

  assign relay_on = relay_r;
  assign power_ok = out_power_r;
  assign action   = out_action_r;

`ifndef ASSERT_OFF
  a_action_marks_change: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ((out_action_r != sght_pkg::ACT_NONE) == (relay_r != $past(relay_r))))
    else $error("action code disagrees with relay change");
  a_turn_on_by_temp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(relay_r) |-> (out_action_r == sght_pkg::ACT_ON_TEMP))
    else $error("relay turned on without on-by-temperature action");
`endif

endmodule

`default_nettype wire

// File: hdl/sght_ctrl.sv
`default_nettype none

module sght_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output sght_pkg::cmd_t          cmd,
  input  wire sght_pkg::status_t  status
);

  sght_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sght_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sght_pkg::S_DIV;
        end
      end
      sght_pkg::S_DIV: begin
        if (status.div_done) begin
          state_nxt = sght_pkg::S_DONE;
        end
      end
      sght_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = sght_pkg::S_IDLE;
        end
      end
      default: state_nxt = sght_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      sght_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      sght_pkg::S_DIV: begin
        cmd.step = 1'b1;
      end
      sght_pkg::S_DONE: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sght_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == sght_pkg::S_DIV))
    else $error("accepted beat did not start the division");
  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over an untaken beat");
  a_div_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sght_pkg::S_DIV && status.div_done) |=> (state_r == sght_pkg::S_DONE))
    else $error("division end did not reach the result state");
`endif

endmodule

`default_nettype wire

// File: hdl/solar_gated_heater_thermostat.sv
`default_nettype none

// Channel   Dir  Ports                          Content
// in_       in   in_tvalid/in_tready/in_tdata   one evaluation request per beat
// out_      out  out_tvalid/out_tready/out_tdata one relay decision per request
// cfg_      in   cfg_we/cfg_index/cfg_wdata     threshold register writes
//
// An item is accepted, then the serial heater-current divider works out its DIV_W
// quotient bits, DIV_W = clog2(HEATER_POWER_MW * 1000 + 1), then it is committed.
// No beat is accepted during the division. Reset is synchronous and active low.
// A new beat is accepted while the previous result waits; a stalled output holds
// the commit of the next one.

module solar_gated_heater_thermostat #(
  parameter int HEATER_POWER_MW      = 16800,
  parameter int MIN_VALID_BATTERY_MV = 1000
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // now_ms[31:0], sensor_present[32], water_temp[44:33], battery_mv[60:45],
  // panel_mv[76:61], battery_ma[95:77], panel_watts[107:96], zeros above
  input  wire logic [111:0]                      in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // relay_on[0], power_ok[1], action[4:2], zeros above
  output logic [7:0]                             out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [sght_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sght_pkg::CFG_W-1:0]        cfg_wdata
);

  sght_pkg::cmd_t    cmd;
  sght_pkg::status_t status;
  logic              relay_on;
  logic              power_ok;
  sght_pkg::action_t action;

  sght_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  sght_dp #(
    .HEATER_POWER_MW      (HEATER_POWER_MW),
    .MIN_VALID_BATTERY_MV (MIN_VALID_BATTERY_MV)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .now_ms         (in_tdata[31:0]),
    .sensor_present (in_tdata[32]),
    .water_temp     ($signed(in_tdata[44:33])),
    .battery_mv     (in_tdata[60:45]),
    .panel_mv       (in_tdata[76:61]),
    .battery_ma     ($signed(in_tdata[95:77])),
    .panel_watts    (in_tdata[107:96]),
    .relay_on       (relay_on),
    .power_ok       (power_ok),
    .action         (action)
  );

  assign out_tdata = {3'b000, action, power_ok, relay_on};

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int HEATER_MW     = 16800;
  localparam int MIN_BATT_MV   = 1000;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;

  typedef struct packed {
    logic [3:0]  pad;
    logic [11:0] panel_watts;
    logic [18:0] battery_ma;
    logic [15:0] panel_mv;
    logic [15:0] battery_mv;
    logic [11:0] water_temp;
    logic        sensor_present;
    logic [31:0] now_ms;
  } eval_req_t;

  typedef struct packed {
    logic [2:0]        pad;
    sght_pkg::action_t action;
    logic              power_ok;
    logic              relay_on;
  } decision_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic [111:0]                   in_tdata   = '0;
  logic                           out_tready = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [sght_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [sght_pkg::CFG_W-1:0]     cfg_wdata  = '0;
  wire                            in_tready;
  wire                            out_tvalid;
  wire  [7:0]                     out_tdata;

  // Thresholds as the block should hold them.
  logic signed [11:0] temp_on_q    = 12'sd320;
  logic signed [11:0] temp_off_q   = 12'sd384;
  logic [15:0]        cutoff_q     = 16'd11800;
  logic signed [18:0] margin_on_q  = 19'sd200;
  logic signed [18:0] margin_off_q = 19'sd50;
  logic [11:0]        panel_on_q   = 12'd23;
  logic [11:0]        panel_keep_q = 12'd20;
  logic [15:0]        timeout_q    = 16'd30000;

  logic        relay_q      = 1'b0;
  logic        lost_q       = 1'b0;
  logic [31:0] lost_since_q = '0;

  eval_req_t requests_pending[$];
  decision_t decisions_due[$];

  int          items_queued = 0;
  int          items_taken  = 0;
  int          mismatches   = 0;
  int          idle_cycles  = 0;
  logic [31:0] sim_ms       = '0;
  bit          sensor_up    = 1'b1;
  bit          no_idle      = 1'b0;
  bit          in_fire      = 1'b0;

  solar_gated_heater_thermostat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic decision_t decide_relay(eval_req_t r);
    decision_t   d;
    logic        was_on, by_cutoff, panel_ok, trend_ok, pwr_ok;
    longint      load_ma, charge_ma;
    logic [31:0] elapsed;
    d = '0;
    was_on = relay_q;
    load_ma = 0;
    charge_ma = longint'($signed(r.battery_ma));
    by_cutoff = (r.battery_mv > cutoff_q) || (r.panel_mv > cutoff_q);
    panel_ok = r.panel_watts >= (was_on ? panel_keep_q : panel_on_q);
    if (r.battery_mv >= MIN_BATT_MV) begin
      load_ma = (longint'(HEATER_MW) * 1000) / longint'(r.battery_mv);
    end
    if (was_on) begin
      trend_ok = charge_ma >= longint'(margin_off_q);
    end else begin
      trend_ok = (charge_ma - load_ma) >= longint'(margin_on_q);
    end
    pwr_ok = by_cutoff || (panel_ok && trend_ok);
    d.action = sght_pkg::ACT_NONE;
    if (!r.sensor_present) begin
      if (!lost_q) begin
        lost_q = 1'b1;
        lost_since_q = r.now_ms;
      end
      elapsed = r.now_ms - lost_since_q;
      if (elapsed >= {16'd0, timeout_q}) begin
        relay_q = 1'b0;
        if (was_on) d.action = sght_pkg::ACT_OFF_FAIL;
      end
    end else begin
      lost_q = 1'b0;
      if (!pwr_ok) begin
        relay_q = 1'b0;
        if (was_on) d.action = sght_pkg::ACT_OFF_PWR;
      end else if (!was_on && $signed(r.water_temp) <= temp_on_q) begin
        relay_q = 1'b1;
        d.action = sght_pkg::ACT_ON_TEMP;
      end else if (was_on && $signed(r.water_temp) >= temp_off_q) begin
        relay_q = 1'b0;
        d.action = sght_pkg::ACT_OFF_TEMP;
      end
    end
    d.relay_on = relay_q;
    d.power_ok = pwr_ok;
    return d;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic eval_req_t make_req(logic [31:0] now, bit present, int temp,
                                         int bmv, int pmv, int bma, int pw);
    eval_req_t r;
    r = '0;
    r.now_ms = now;
    r.sensor_present = present;
    r.water_temp = temp[11:0];
    r.battery_mv = bmv[15:0];
    r.panel_mv = pmv[15:0];
    r.battery_ma = bma[18:0];
    r.panel_watts = pw[11:0];
    return r;
  endfunction

  // Fields are mostly placed next to the active thresholds so that both sides
  // of every comparison are reached, with full-range values mixed in.
  function automatic eval_req_t random_req();
    int temp, bmv, pmv, bma, pw, load;
    case ($urandom_range(19))
      0: sim_ms = $urandom();
      1, 2: sim_ms = sim_ms + $urandom_range(100000);
      3: sim_ms = sim_ms;
      default: sim_ms = sim_ms + $urandom_range(3000);
    endcase
    if ($urandom_range(99) < 6) sensor_up = !sensor_up;
    case ($urandom_range(5))
      0: temp = int'($urandom_range(2880)) - 880;
      1, 2: temp = int'(temp_on_q) + int'($urandom_range(6)) - 3;
      3, 4: temp = int'(temp_off_q) + int'($urandom_range(6)) - 3;
      default: temp = $urandom_range(1) ? 2000 : -880;
    endcase
    temp = clamp(temp, -880, 2000);
    case ($urandom_range(5))
      0: bmv = $urandom_range(65535);
      1: bmv = MIN_BATT_MV + int'($urandom_range(20)) - 10;
      2: bmv = int'(cutoff_q) + int'($urandom_range(6)) - 3;
      3: bmv = $urandom_range(1) ? 0 : 65535;
      default: bmv = $urandom_range(14000, 10000);
    endcase
    bmv = clamp(bmv, 0, 65535);
    case ($urandom_range(3))
      0: pmv = $urandom_range(65535);
      1: pmv = int'(cutoff_q) + int'($urandom_range(6)) - 3;
      default: pmv = $urandom_range(cutoff_q);
    endcase
    pmv = clamp(pmv, 0, 65535);
    load = (bmv >= MIN_BATT_MV) ? HEATER_MW * 1000 / bmv : 0;
    case ($urandom_range(4))
      0: bma = int'($urandom_range(400000)) - 200000;
      1: bma = $urandom_range(1) ? 200000 : -200000;
      2: bma = int'(margin_off_q) + int'($urandom_range(4)) - 2;
      default: bma = int'(margin_on_q) + load + int'($urandom_range(4)) - 2;
    endcase
    bma = clamp(bma, -200000, 200000);
    case ($urandom_range(4))
      0: pw = $urandom_range(4095);
      1: pw = int'(panel_on_q) + int'($urandom_range(4)) - 2;
      2: pw = int'(panel_keep_q) + int'($urandom_range(4)) - 2;
      3: pw = $urandom_range(1) ? 4095 : 0;
      default: pw = $urandom_range(200);
    endcase
    pw = clamp(pw, 0, 4095);
    return make_req(sim_ms, sensor_up, temp, bmv, pmv, bma, pw);
  endfunction

  task automatic push_req(eval_req_t r);
    requests_pending.push_back(r);
    items_queued++;
  endtask

  task automatic write_reg(logic [sght_pkg::CFG_IDX_W-1:0] idx, int value);
    logic [sght_pkg::CFG_W-1:0] w;
    w = value[sght_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= w;
    case (idx)
      sght_pkg::CFG_TEMP_ON:    temp_on_q = w[11:0];
      sght_pkg::CFG_TEMP_OFF:   temp_off_q = w[11:0];
      sght_pkg::CFG_CUTOFF_MV:  cutoff_q = w[15:0];
      sght_pkg::CFG_MARGIN_ON:  margin_on_q = w;
      sght_pkg::CFG_MARGIN_OFF: margin_off_q = w;
      sght_pkg::CFG_PANEL_ON:   panel_on_q = w[11:0];
      sght_pkg::CFG_PANEL_KEEP: panel_keep_q = w[11:0];
      sght_pkg::CFG_TIMEOUT:    timeout_q = w[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(int ton, int toff, int cut, int mon, int moff,
                              int pon, int pkeep, int tout);
    write_reg(sght_pkg::CFG_TEMP_ON, ton);
    write_reg(sght_pkg::CFG_TEMP_OFF, toff);
    write_reg(sght_pkg::CFG_CUTOFF_MV, cut);
    write_reg(sght_pkg::CFG_MARGIN_ON, mon);
    write_reg(sght_pkg::CFG_MARGIN_OFF, moff);
    write_reg(sght_pkg::CFG_PANEL_ON, pon);
    write_reg(sght_pkg::CFG_PANEL_KEEP, pkeep);
    write_reg(sght_pkg::CFG_TIMEOUT, tout);
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || decisions_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (requests_pending.size() > 0 && (no_idle || $urandom_range(99) >= 15)) begin
        in_tdata <= requests_pending.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin : monitor
    decision_t got, want;
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      decisions_due.push_back(decide_relay(in_tdata));
      items_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (decisions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %b", out_tdata);
      end else begin
        want = decisions_due.pop_front();
        if (got.relay_on !== want.relay_on || got.power_ok !== want.power_ok ||
            got.action !== want.action || got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("decision mismatch: expected relay=%0d power=%0d action=%0d pad=%0d",
                     want.relay_on, want.power_ok, want.action, want.pad);
            $display("                   got      relay=%0d power=%0d action=%0d pad=%0d",
                     got.relay_on, got.power_ok, got.action, got.pad);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_req(make_req(32'd0, 1, -880, 12000, 0, 0, 0));
    push_req(make_req(32'd100, 1, 2000, 12000, 0, 0, 0));
    push_req(make_req(32'd200, 1, 320, 12000, 0, 0, 0));
    push_req(make_req(32'd300, 1, 384, 12000, 0, 0, 0));
    push_req(make_req(32'd400, 1, 0, 12000, 0, 0, 0));
    push_req(make_req(32'd500, 1, 0, 0, 0, -200000, 0));
    push_req(make_req(32'd600, 1, 0, 999, 0, 200, 23));
    push_req(make_req(32'd700, 1, 100, 999, 0, 50, 20));
    push_req(make_req(32'd800, 1, 100, 999, 0, 50, 19));
    push_req(make_req(32'd900, 1, 100, 1000, 11800, 200000, 4095));
    push_req(make_req(32'd1000, 0, 100, 12000, 0, 0, 0));
    push_req(make_req(32'd30999, 0, 100, 12000, 0, 0, 0));
    push_req(make_req(32'd31000, 0, 100, 12000, 0, 0, 0));
    push_req(make_req(32'd40000, 0, -880, 12000, 0, 0, 0));
    push_req(make_req(32'd41000, 1, -880, 65535, 65535, -1, 4095));
    push_req(make_req(32'hFFFFF000, 0, 0, 12000, 0, 0, 0));
    push_req(make_req(32'h00006000, 0, 0, 12000, 0, 0, 0));
    push_req(make_req(32'h00006530, 0, 0, 12000, 0, 0, 0));
    push_req(make_req(32'h00007000, 1, 2000, 65535, 65535, -200000, 4095));
    push_req(make_req(32'h00008000, 1, -880, 65535, 0, 0, 0));
    push_req(make_req(32'h00009000, 1, -880, 1000, 1000, -200000, 0));
    push_req(make_req(32'hFFFFFFFF, 1, -1, 12000, 0, -1, 0));
    wait_idle();
    sim_ms = 32'd50000;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_regs(320, 384, 11800, 200, 50, 23, 20, 30000);
        1: program_regs(320, 384, 65535, 200, 50, 23, 20, 5000);
        2: program_regs(0, 100, 0, 0, 0, 0, 0, 0);
        3: program_regs(2000, -880, 65535, -200000, 200000, 0, 4095, 65535);
        4: program_regs(-880, 2000, 1000, 200000, -200000, 4095, 0, 1);
        default: program_regs(int'($urandom_range(2880)) - 880,
                              int'($urandom_range(2880)) - 880,
                              $urandom_range(1) ? $urandom_range(14000, 10000)
                                                : $urandom_range(65535),
                              int'($urandom_range(4000)) - 2000,
                              int'($urandom_range(4000)) - 2000,
                              $urandom_range(60), $urandom_range(60),
                              $urandom_range(1) ? $urandom_range(10000)
                                                : $urandom_range(65535));
      endcase
      no_idle = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) push_req(random_req());
      wait_idle();
    end

    if (mismatches == 0 && decisions_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
